FILE: sv/bems_pkg.sv
// bems_pkg: types, codes and byte-lane helpers for the byte enable memory slave
// no dependencies; imported by bems_ctrl, bems_dpath and byte_enable_memory_slave

package bems_pkg;

  localparam int DEPTH_DEFAULT = 4096;
  localparam int IDX_W         = 12;
  localparam int SIZE_W        = 13;
  localparam int DATA_W        = 64;
  localparam int BE_W          = 8;

  localparam logic [SIZE_W-1:0] WORDS_RESET = 13'd4096;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD        = 2'd1;
  localparam logic [1:0] STAT_MISALIGNED = 2'd2;

  localparam logic [BE_W-1:0] BE_B0    = 8'h01;
  localparam logic [BE_W-1:0] BE_H0    = 8'h03;
  localparam logic [BE_W-1:0] BE_H1    = 8'h0C;
  localparam logic [BE_W-1:0] BE_H2    = 8'h30;
  localparam logic [BE_W-1:0] BE_H3    = 8'hC0;
  localparam logic [BE_W-1:0] BE_W0    = 8'h0F;
  localparam logic [BE_W-1:0] BE_W1    = 8'hF0;
  localparam logic [BE_W-1:0] BE_ALL   = 8'hFF;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  word_index;
    logic [BE_W-1:0]   byte_enables;
    logic [DATA_W-1:0] write_data;
    logic              burst;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              bus_error;
    logic [1:0]        access_status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic mem_access;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } stat_t;

  function automatic logic [DATA_W-1:0] lane_mask(input logic [BE_W-1:0] be);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < BE_W; i++) begin
      if (be[i]) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic aligned_pattern(input logic [BE_W-1:0] be);
    logic one_hot;
    one_hot = (be != '0) && ((be & (be - BE_B0)) == '0);
    return one_hot || be == BE_H0 || be == BE_H1 || be == BE_H2 || be == BE_H3 ||
           be == BE_W0 || be == BE_W1;
  endfunction

  // lowest contiguous run of set bits
  function automatic logic [BE_W-1:0] lowest_run(input logic [BE_W-1:0] be);
    logic [BE_W-1:0] low;
    logic [BE_W-1:0] sum;
    low = be & (~be + BE_B0);
    sum = be + low;
    return be & ~sum;
  endfunction

endpackage

FILE: sv/bems_ctrl.sv
// bems_ctrl: controller for the byte enable memory slave (clear sweep, access, result)
// depends on bems_pkg; drives commands into bems_dpath

module bems_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bems_pkg::cmd_t cmd,
  input  bems_pkg::stat_t stat
);
  import bems_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_ACCESS;
      S_ACCESS: state_nxt = S_RESULT;
      S_RESULT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_ACCESS: cmd.mem_access = 1'b1;
      S_RESULT: cmd.load_rsp = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_rsp) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/bems_dpath.sv
// bems_dpath: word store, size register, request decode and result register
// depends on bems_pkg; commanded by bems_ctrl

module bems_dpath #(
  parameter int DEPTH = bems_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bems_pkg::cmd_t              cmd,
  output bems_pkg::stat_t             stat,
  input  bems_pkg::req_t              in_req,
  output bems_pkg::rsp_t              out_rsp,
  input  logic                        cfg_we,
  input  logic [bems_pkg::SIZE_W-1:0] cfg_wdata
);
  import bems_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [SIZE_W-1:0] words_r, words_nxt;
  req_t              req_r;
  rsp_t              rsp_r, rsp_nxt;

  logic [AW-1:0]     mem_addr;
  logic              in_range;
  logic [BE_W-1:0]   run;
  logic [BE_W-1:0]   rest;
  logic              wr_ok;
  logic [31:0]       burst_val;

  assign mem_addr = AW'(req_r.word_index);
  assign in_range = ({1'b0, req_r.word_index} < words_r) &&
                    (32'(req_r.word_index) < 32'(DEPTH));
  assign run      = lowest_run(req_r.byte_enables);
  assign rest     = req_r.byte_enables & ~run;
  assign wr_ok    = in_range && (req_r.byte_enables != '0);

  // run length of 1, 2, 4 or 8 lanes
  logic len_ok;
  always_comb begin
    case ($countones(run))
      1, 2, 4, 8: len_ok = 1'b1;
      default:    len_ok = 1'b0;
    endcase
  end

  assign burst_val = {17'd0, req_r.word_index, 3'd0} +
                     ((req_r.byte_enables == BE_W1) ? 32'd4 : 32'd0);

  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.access_status = STAT_OK;
    if (req_r.kind) begin
      if (!wr_ok) begin
        rsp_nxt.access_status = STAT_BAD;
      end else if (aligned_pattern(req_r.byte_enables) || req_r.byte_enables == BE_ALL) begin
        rsp_nxt.access_status = STAT_OK;
      end else if (len_ok && rest == '0) begin
        rsp_nxt.access_status = STAT_MISALIGNED;
      end else begin
        rsp_nxt.access_status = STAT_BAD;
      end
    end else if (req_r.burst) begin
      if (req_r.byte_enables == BE_W1) begin
        rsp_nxt.read_data = {burst_val, 32'd0};
      end else begin
        rsp_nxt.read_data = {32'd0, burst_val};
      end
    end else if (!in_range || !aligned_pattern(req_r.byte_enables)) begin
      rsp_nxt.bus_error     = 1'b1;
      rsp_nxt.access_status = STAT_BAD;
    end else begin
      rsp_nxt.read_data = mem_q_r & lane_mask(req_r.byte_enables);
    end
  end

  assign clr_addr_nxt = cmd.clr_step ? clr_addr_r + AW'(1) : clr_addr_r;
  assign words_nxt    = cfg_we ? cfg_wdata : words_r;
  assign stat.clr_done = (clr_addr_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      words_r    <= WORDS_RESET;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      words_r    <= words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_req;
    if (cmd.load_rsp) rsp_r <= rsp_nxt;
  end

  // byte-lane write port, registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.mem_access && req_r.kind && wr_ok) begin
      for (int i = 0; i < BE_W; i++) begin
        if (run[i]) mem[mem_addr][8*i +: 8] <= req_r.write_data[8*i +: 8];
      end
    end
    if (cmd.mem_access) mem_q_r <= mem[mem_addr];
  end

  assign out_rsp = rsp_r;

endmodule

FILE: sv/byte_enable_memory_slave.sv
// byte_enable_memory_slave: top level of the 64-bit byte enable memory slave
// depends on bems_pkg, bems_ctrl and bems_dpath
//
//   channel   ports                       moves
//   in        in_valid/in_ready/in_req    one request (req_t)
//   out       out_valid/out_ready/out_rsp one result (rsp_t)
//   cfg       cfg_we/cfg_wdata            words_in_use, 13 bits
//
// each request passes through the controller sequence: idle (accept into
// the request register), access (memory port access), result (output load);
// out_valid rises when the result step loads the output register
// after reset a clearing pass zeroes the store, with in_ready low
// a new request is taken while a result waits in the output register
// out_ready low holds the result and stalls the next request in its result step

module byte_enable_memory_slave #(
  parameter int DEPTH = bems_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bems_pkg::req_t              in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bems_pkg::rsp_t              out_rsp,
  input  logic                        cfg_we,
  input  logic [bems_pkg::SIZE_W-1:0] cfg_wdata
);
  import bems_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bems_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bems_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule
